>>> src/gddw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gddw_pkg
// Types, constants and helper functions of the Gregorian day difference and
// weekday unit.
// ----------------------------------------------------------------------------
package gddw_pkg;

   typedef logic [13:0]        year_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         mday_type;
   typedef logic [22:0]        abs_day_type;
   typedef logic signed [22:0] diff_type;
   typedef logic [2:0]         weekday_type;
   typedef logic [8:0]         ord_day_type;

   typedef enum logic {
      ACT_DIFF    = 1'b0,
      ACT_WEEKDAY = 1'b1
   } action_type;

   typedef struct packed {
      year_type  year;
      month_type month;
      mday_type  day;
   } date_type;

   // Days of the months before each month, common year.
   localparam ord_day_type MONTH_BASE [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // Absolute day count of 1970-01-01.
   localparam abs_day_type EPOCH_DAY    = 23'd719529;
   // (day - EPOCH_DAY + Thursday) mod 7 equals (day + 5) mod 7.
   localparam logic [2:0]  WEEKDAY_BIAS = 3'd5;

   // Reciprocal of 25 scaled by 2^23, exact for all 13-bit dividends.
   localparam logic [18:0] DIV25_MUL    = 19'd335545;
   localparam int          DIV25_SHIFT  = 23;

   localparam diff_type    DIFF_MAX     = 23'sh3FFFFF;
   localparam diff_type    DIFF_MIN     = 23'sh400000;

   function automatic logic [8:0] div25(input logic [12:0] x);
      logic [31:0] p;
      p = 32'(x) * 32'(DIV25_MUL);
      return p[DIV25_SHIFT +: 9];
   endfunction

   function automatic ord_day_type month_base(input month_type m);
      ord_day_type r;
      if (m == 4'd0) begin
         r = '0;
      end else if (m > 4'd12) begin
         r = MONTH_BASE[11];
      end else begin
         r = MONTH_BASE[4'(m - 4'd1)];
      end
      return r;
   endfunction

   // 2^3 is 1 mod 7: fold octal digits until the value is small.
   function automatic weekday_type mod7(input logic [23:0] v);
      logic [5:0] s;
      logic [3:0] t;
      logic [3:0] u;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 6'(v[3*i +: 3]);
      end
      t = 4'(s[5:3]) + 4'(s[2:0]);
      u = 4'(t[3]) + 4'(t[2:0]);
      return (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
   endfunction

endpackage
`default_nettype wire

>>> src/gddw_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gddw_req_if
// Request channel: action and two dates, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gddw_req_if import gddw_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   year_type   from_year;
   month_type  from_month;
   mday_type   from_day;
   year_type   to_year;
   month_type  to_month;
   mday_type   to_day;

   modport source (
      output valid, action, from_year, from_month, from_day, to_year, to_month, to_day,
      input  ready
   );
   modport sink (
      input  valid, action, from_year, from_month, from_day, to_year, to_month, to_day,
      output ready
   );
endinterface
`default_nettype wire

>>> src/gddw_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gddw_rsp_if
// Response channel: day difference and weekday, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gddw_rsp_if import gddw_pkg::*; ();
   logic        valid;
   logic        ready;
   diff_type    day_difference;
   weekday_type weekday;

   modport source (output valid, day_difference, weekday, input ready);
   modport sink (input valid, day_difference, weekday, output ready);
endinterface
`default_nettype wire

>>> src/gregorian_day_difference_weekday_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_day_difference_weekday_unit
// Days between two Gregorian dates, or offset from 1970-01-01 and weekday.
// ----------------------------------------------------------------------------
// Path: an accepted request moves from stage 1 through stage 2 into the response register.
// Throughput: one request per cycle while rsp.ready holds; three register stages (request, day
//   counts, response) each advance on their own, so bubbles are squeezed out.
// Reset: synchronous, active high; clears all stage valid bits, payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module gregorian_day_difference_weekday_unit import gddw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   gddw_req_if.sink      req,
   gddw_rsp_if.source    rsp
);

   // Stage 1: captured request
   logic        s1_valid_ff,  s1_valid_in;
   action_type  s1_action_ff, s1_action_in;
   date_type    s1_from_ff,   s1_from_in;
   date_type    s1_to_ff,     s1_to_in;

   // Stage 2: absolute day counts
   logic        s2_valid_ff,  s2_valid_in;
   action_type  s2_action_ff, s2_action_in;
   abs_day_type s2_first_ff,  s2_first_in;
   abs_day_type s2_second_ff, s2_second_in;

   // Output register
   logic        rsp_valid_ff,   rsp_valid_in;
   diff_type    rsp_diff_ff,    rsp_diff_in;
   weekday_type rsp_weekday_ff, rsp_weekday_in;

   logic        out_en;
   logic        s2_en;
   logic        s1_en;

   abs_day_type first_day;
   abs_day_type second_day;
   diff_type    diff_val;
   weekday_type weekday_val;

   // Each stage loads when empty or when its contents move on this cycle.
   assign out_en    = !rsp_valid_ff || rsp.ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req.ready = s1_en;

   gddw_abs_day u_first (
      .date    (s1_from_ff),
      .abs_day (first_day)
   );

   gddw_abs_day u_second (
      .date    (s1_to_ff),
      .abs_day (second_day)
   );

   gddw_result u_result (
      .action         (s2_action_ff),
      .first_day      (s2_first_ff),
      .second_day     (s2_second_ff),
      .day_difference (diff_val),
      .weekday        (weekday_val)
   );

   always_comb begin
      // hold by default
      s1_valid_in    = s1_valid_ff;
      s1_action_in   = s1_action_ff;
      s1_from_in     = s1_from_ff;
      s1_to_in       = s1_to_ff;
      s2_valid_in    = s2_valid_ff;
      s2_action_in   = s2_action_ff;
      s2_first_in    = s2_first_ff;
      s2_second_in   = s2_second_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_diff_in    = rsp_diff_ff;
      rsp_weekday_in = rsp_weekday_ff;

      if (s1_en) begin
         s1_valid_in  = req.valid;
         s1_action_in = req.action;
         s1_from_in   = '{year: req.from_year, month: req.from_month, day: req.from_day};
         s1_to_in     = '{year: req.to_year, month: req.to_month, day: req.to_day};
      end
      if (s2_en) begin
         s2_valid_in  = s1_valid_ff;
         s2_action_in = s1_action_ff;
         s2_first_in  = first_day;
         s2_second_in = second_day;
      end
      if (out_en) begin
         rsp_valid_in   = s2_valid_ff;
         rsp_diff_in    = diff_val;
         rsp_weekday_in = weekday_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_action_ff   <= s1_action_in;
      s1_from_ff     <= s1_from_in;
      s1_to_ff       <= s1_to_in;
      s2_action_ff   <= s2_action_in;
      s2_first_ff    <= s2_first_in;
      s2_second_ff   <= s2_second_in;
      rsp_diff_ff    <= rsp_diff_in;
      rsp_weekday_ff <= rsp_weekday_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.day_difference = rsp_diff_ff;
   assign rsp.weekday        = rsp_weekday_ff;

   // An accepted request lands in stage 1.
   a_req_capture: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> s1_valid_ff)
      else $error("accepted request not captured");

   // Stage 2 contents move to the output whenever the output can load.
   a_s2_advance: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_en) |=> rsp_valid_ff)
      else $error("day counts dropped before the response register");

   // A full stage 1 that cannot advance blocks new requests.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_en) |-> !req.ready)
      else $error("request accepted over a stalled stage");

   // Weekday stays in range.
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_weekday_ff <= 3'd6))
      else $error("weekday out of range");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
`default_nettype wire

>>> src/gddw_abs_day.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gddw_abs_day
// Map a date to its absolute day count since year 0 (proleptic Gregorian).
// ----------------------------------------------------------------------------
module gddw_abs_day import gddw_pkg::*; (
   input  date_type    date,
   output abs_day_type abs_day
);

   logic [14:0] y_p3;
   logic [14:0] y_p99;
   logic [14:0] y_p399;
   logic [8:0]  cent_cnt;
   logic [8:0]  quad_cnt;
   logic [22:0] year_days;
   logic [11:0] k;
   logic [8:0]  k_q;
   logic        k_mult25;
   logic        leap;
   ord_day_type ord;

   assign y_p3   = 15'(date.year) + 15'd3;
   assign y_p99  = 15'(date.year) + 15'd99;
   assign y_p399 = 15'(date.year) + 15'd399;

   // floor(a/100) = floor(floor(a/4)/25), floor(a/400) = floor(floor(a/16)/25)
   assign cent_cnt = div25(y_p99[14:2]);
   assign quad_cnt = div25(13'(y_p399[14:4]));

   assign year_days = 23'(date.year) * 23'd365 + 23'(y_p3[14:2])
                      - 23'(cent_cnt) + 23'(quad_cnt);

   // Leap: divisible by 4, and by 16 or not by 25.
   assign k        = date.year[13:2];
   assign k_q      = div25(13'(k));
   assign k_mult25 = (14'(k) == 14'(k_q) * 14'd25);
   assign leap     = (date.year[1:0] == 2'd0) && ((date.year[3:2] == 2'd0) || !k_mult25);

   assign ord = 9'(date.day) + month_base(date.month)
                + 9'((date.month > 4'd2) && leap);

   assign abs_day = year_days + 23'(ord);

endmodule
`default_nettype wire

>>> src/gddw_result.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gddw_result
// Form the saturated day difference and the weekday from two day counts.
// ----------------------------------------------------------------------------
module gddw_result import gddw_pkg::*; (
   input  action_type  action,
   input  abs_day_type first_day,
   input  abs_day_type second_day,
   output diff_type    day_difference,
   output weekday_type weekday
);

   logic signed [23:0] diff_wide;

   always_comb begin
      if (action == ACT_WEEKDAY) begin
         diff_wide = $signed({1'b0, first_day}) - $signed({1'b0, EPOCH_DAY});
         weekday   = mod7(24'(first_day) + 24'(WEEKDAY_BIAS));
      end else begin
         diff_wide = $signed({1'b0, second_day}) - $signed({1'b0, first_day});
         weekday   = '0;
      end
      // clamp when the top two bits disagree
      if (diff_wide[23] != diff_wide[22]) begin
         day_difference = diff_wide[23] ? DIFF_MIN : DIFF_MAX;
      end else begin
         day_difference = diff_wide[22:0];
      end
   end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian day difference and weekday unit.
// A scoreboard class predicts each response from the accepted request and
// compares it field by field. Directed requests cover the calendar corners,
// then about 1200 random requests run with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top import gddw_pkg::*; ();

   // Cap on run time; far above the slowest legal run.
   localparam int unsigned RUN_LIMIT    = 4_000_000;
   localparam int unsigned RANDOM_COUNT = 1200;
   // Let the pipeline settle after the last response.
   localparam int unsigned TAIL_CYCLES  = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each response and checks it in arrival order.
   // -------------------------------------------------------------------------
   class date_scoreboard;
      typedef struct {
         diff_type    days;
         weekday_type wday;
      } answer_type;

      localparam longint DAYS_TOP    = 4194303;
      localparam longint DAYS_BOTTOM = -4194304;
      localparam int     THURSDAY    = 4;
      localparam int     PRINT_CAP   = 40;

      answer_type  pending_q[$];
      int unsigned mismatches;
      int unsigned responses;
      int unsigned diff_requests;
      int unsigned weekday_requests;
      int unsigned saturated;

      function new();
         mismatches       = 0;
         responses        = 0;
         diff_requests    = 0;
         weekday_requests = 0;
         saturated        = 0;
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      // Days of the months before month m, common year; m is 1..12.
      function longint prior_months(int unsigned m);
         case (m)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
         endcase
      endfunction

      function bit leap(longint y);
         return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      endfunction

      // Absolute day number: whole years before the date plus its ordinal day.
      function longint day_count(date_type d);
         longint      y;
         longint      ord;
         int unsigned m;
         y   = longint'(d.year);
         m   = d.month;
         ord = longint'(d.day);
         if (m > 12) m = 12;
         if (m >= 1) ord += prior_months(m);
         if (m > 2 && leap(y)) ord += 1;
         return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + ord;
      endfunction

      function diff_type clamp_days(longint v);
         if (v > DAYS_TOP) begin
            saturated++;
            v = DAYS_TOP;
         end else if (v < DAYS_BOTTOM) begin
            saturated++;
            v = DAYS_BOTTOM;
         end
         return diff_type'(v);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      function void note_request(action_type act, date_type first, date_type second);
         date_type   epoch;
         longint     start;
         longint     off;
         answer_type ans;
         epoch = '{year: 14'd1970, month: 4'd1, day: 5'd1};
         start = day_count(first);
         if (act == ACT_DIFF) begin
            diff_requests++;
            off      = day_count(second) - start;
            ans.wday = '0;
         end else begin
            weekday_requests++;
            off      = start - day_count(epoch);
            // Weekday comes from the exact offset, never the clamped one.
            ans.wday = weekday_type'(((off % 7) + 7 + THURSDAY) % 7);
         end
         ans.days = clamp_days(off);
         pending_q.push_back(ans);
      endfunction

      task check_response(diff_type got_days, weekday_type got_wday);
         answer_type ans;
         responses++;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected response: days %0d weekday %0d",
                             got_days, got_wday));
            return;
         end
         ans = pending_q.pop_front();
         if (got_days !== ans.days)
            report($sformatf("response %0d: day_difference %0d, predicted %0d",
                             responses, got_days, ans.days));
         if (got_wday !== ans.wday)
            report($sformatf("response %0d: weekday %0d, predicted %0d",
                             responses, got_wday, ans.wday));
      endtask
   endclass

   logic clock;
   logic reset;

   gddw_req_if req_bus ();
   gddw_rsp_if rsp_bus ();

   date_scoreboard sb = new();

   int unsigned drains;
   int unsigned long_gaps;

   gregorian_day_difference_weekday_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: a hung handshake ends here.
   initial begin
      #(RUN_LIMIT);
      $display("timeout: %0d requests still outstanding", sb.outstanding());
      $display("tb_top NOT OK");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------
   function automatic date_type mk_date(int unsigned y, int unsigned m, int unsigned d);
      date_type r;
      r.year  = year_type'(y);
      r.month = month_type'(m);
      r.day   = mday_type'(d);
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap(bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic year_type rand_year();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return year_type'($urandom_range(0, 9999));
         6, 7:             return year_type'($urandom_range(1900, 2100));
         8:                return year_type'($urandom_range(10000, 16383));
         default:          return year_type'($urandom_range(0, 16383));
      endcase
   endfunction

   // Well-formed dates most of the time; odd months and days otherwise.
   function automatic date_type rand_date();
      date_type    d;
      int unsigned r;
      d.year = rand_year();
      r      = $urandom_range(0, 19);
      d.month = (r < 18) ? month_type'($urandom_range(1, 12))
                         : month_type'($urandom_range(0, 15));
      r      = $urandom_range(0, 19);
      if (r < 17)      d.day = mday_type'($urandom_range(1, 28));
      else if (r < 19) d.day = mday_type'($urandom_range(1, 31));
      else             d.day = mday_type'($urandom_range(0, 31));
      return d;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   // Present one request and hold it until accepted. Valid stays high on
   // return so a back-to-back request needs no second assignment this step.
   task automatic send_query(action_type act, date_type first, date_type second);
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.from_year  <= first.year;
      req_bus.from_month <= first.month;
      req_bus.from_day   <= first.day;
      req_bus.to_year    <= second.year;
      req_bus.to_month   <= second.month;
      req_bus.to_day     <= second.day;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(act, first, second);
   endtask

   // Drop valid and idle for the requested gap; nothing to do for n == 0.
   task automatic idle_sender(int unsigned n);
      if (n > 0) begin
         if (n >= 8) long_gaps++;
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold off until every response is back; a clock edge always passes before the first check.
   task automatic drain_responses();
      drains++;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic directed_query(action_type act,
                                 int unsigned fy, int unsigned fm, int unsigned fd,
                                 int unsigned ty, int unsigned tm, int unsigned td);
      send_query(act, mk_date(fy, fm, fd), mk_date(ty, tm, td));
      idle_sender(pick_gap(1'b0));
   endtask

   task automatic random_query(bit quiet);
      action_type act;
      date_type   first;
      date_type   second;
      act   = action_type'($urandom_range(0, 1));
      first = rand_date();
      if (act == ACT_WEEKDAY) begin
         // Second date is ignored here: drive raw noise into it.
         second = date_type'($urandom);
      end else begin
         second = rand_date();
         if ($urandom_range(0, 3) == 0) second.year = first.year;
      end
      send_query(act, first, second);
      idle_sender(pick_gap(quiet));
   endtask

   // -------------------------------------------------------------------------
   // Response side: random backpressure and the checker
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int unsigned r;
         r = $urandom_range(0, 99);
         rsp_bus.ready <= 1'b1;
         // Short runs mostly; some long stretches with no stall at all.
         if (r < 70)      repeat ($urandom_range(1, 8)) @(posedge clock);
         else if (r < 90) repeat ($urandom_range(20, 80)) @(posedge clock);
         else             repeat ($urandom_range(200, 600)) @(posedge clock);
         rsp_bus.ready <= 1'b0;
         r = $urandom_range(0, 99);
         if (r < 85) repeat ($urandom_range(1, 3)) @(posedge clock);
         else        repeat ($urandom_range(10, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_response(rsp_bus.day_difference, rsp_bus.weekday);
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit quiet;
      drains     = 0;
      long_gaps  = 0;
      quiet      = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_DIFF;
      req_bus.from_year  <= '0;
      req_bus.from_month <= '0;
      req_bus.from_day   <= '0;
      req_bus.to_year    <= '0;
      req_bus.to_month   <= '0;
      req_bus.to_day     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Full span of the four-digit calendar, both directions.
      directed_query(ACT_DIFF, 0, 1, 1, 9999, 12, 31);
      directed_query(ACT_DIFF, 9999, 12, 31, 0, 1, 1);
      // All-ones fields: difference leaves the 23-bit range and clamps.
      directed_query(ACT_DIFF, 0, 0, 0, 16383, 15, 31);
      directed_query(ACT_DIFF, 16383, 15, 31, 0, 0, 0);
      // Same date gives zero.
      directed_query(ACT_DIFF, 2024, 2, 29, 2024, 2, 29);
      // Leap rule: divisible by 400, by 100 only, by 4, and year zero.
      directed_query(ACT_DIFF, 2000, 2, 28, 2000, 3, 1);
      directed_query(ACT_DIFF, 1900, 2, 28, 1900, 3, 1);
      directed_query(ACT_DIFF, 2023, 2, 28, 2024, 3, 1);
      directed_query(ACT_DIFF, 0, 2, 29, 0, 3, 1);
      directed_query(ACT_DIFF, 12000, 2, 29, 12000, 3, 1);
      // Month zero counts no prior months and no leap day.
      directed_query(ACT_DIFF, 2020, 0, 5, 2020, 1, 5);
      // Months above twelve act as December.
      directed_query(ACT_DIFF, 2021, 13, 1, 2021, 12, 1);
      directed_query(ACT_DIFF, 2020, 15, 31, 2020, 14, 31);
      // Day zero and days past month end run into the neighbor month.
      directed_query(ACT_DIFF, 2021, 3, 0, 2021, 2, 28);
      directed_query(ACT_DIFF, 2021, 2, 31, 2021, 3, 3);
      // Weekday: the epoch itself, the day before, and the far ends.
      directed_query(ACT_WEEKDAY, 1970, 1, 1, 16383, 15, 31);
      directed_query(ACT_WEEKDAY, 1969, 12, 31, 0, 0, 0);
      directed_query(ACT_WEEKDAY, 0, 1, 1, 9999, 12, 31);
      directed_query(ACT_WEEKDAY, 0, 0, 0, 0, 0, 0);
      directed_query(ACT_WEEKDAY, 9999, 12, 31, 1970, 1, 1);
      // Clamped offset, weekday still from the exact count; then offsets that stay in range.
      directed_query(ACT_WEEKDAY, 16383, 15, 31, 16383, 15, 31);
      directed_query(ACT_WEEKDAY, 10000, 13, 0, 1, 1, 1);
      directed_query(ACT_WEEKDAY, 2000, 3, 1, 5, 5, 5);
      directed_query(ACT_WEEKDAY, 1900, 3, 1, 7, 7, 7);

      // Empty the pipeline once before the random part.
      drain_responses();

      for (int unsigned i = 0; i < RANDOM_COUNT; i++) begin
         // Switch between idling and back-to-back stretches now and then.
         if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
         random_query(quiet);
         if ($urandom_range(0, 199) == 0) drain_responses();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d day differences, %0d weekday queries, %0d clamped",
               sb.diff_requests + sb.weekday_requests, sb.diff_requests,
               sb.weekday_requests, sb.saturated);
      $display("%0d responses checked, %0d full drains, %0d long sender gaps, %0d mismatches",
               sb.responses, drains, long_gaps, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
src/gddw_pkg.sv
src/gddw_req_if.sv
src/gddw_rsp_if.sv
src/gddw_abs_day.sv
src/gddw_result.sv
src/gregorian_day_difference_weekday_unit.sv
dv/tb_top.sv
